// File: rtl/core/bcic_pkg.sv
// ----------------------------------------------------------------------------
// bcic_pkg
// Shared constants for the button, coil and indicator controller.
// ----------------------------------------------------------------------------
package bcic_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W    = 8;
    localparam int OUT_FIELDS = 5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEBOUNCE_PERIOD  = 3'd0,
        REG_LONG_PRESS_COUNT = 3'd1,
        REG_COIL_DELAY       = 3'd2,
        REG_LED_PERIOD       = 3'd3,
        REG_SLOW_BLINK_COUNT = 3'd4
    } cfg_index_t;

    localparam logic [7:0]  DEBOUNCE_PERIOD_RST  = 8'd9;
    localparam logic [7:0]  LONG_PRESS_COUNT_RST = 8'd29;
    localparam logic [15:0] COIL_DELAY_RST       = 16'd399;
    localparam logic [7:0]  LED_PERIOD_RST       = 8'd9;
    localparam logic [7:0]  SLOW_BLINK_COUNT_RST = 8'd20;

    // result word, highest bit first
    typedef struct packed {
        logic short_press;
        logic coil_enabled;
        logic buzzer_on;
        logic led_lit;
        logic coil_on;
    } result_t;

endpackage

// File: rtl/core/button_coil_indicator_controller_top.sv
// ----------------------------------------------------------------------------
// button_coil_indicator_controller_top
// Debounces a button, toggles an enable on a long press, runs the coil
// delay and drives the LED and buzzer; one tick per input word.
// ----------------------------------------------------------------------------
// path: the input register loads at the accept edge; the tick update lands in
//   the result register when the result register is empty or being taken
// throughput: one word per cycle while the output is not stalled; the tick
//   update is a single pass of counter compares between the input register
//   and the result register
// reset: rst_n asynchronous active low; clears the pipeline, restores the
//   tick state and loads the default register values
module button_coil_indicator_controller_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bcic_pkg::TDATA_W-1:0]        s_axis_tdata,  // [0] button_pressed
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] coil_on, [1] led_lit, [2] buzzer_on, [3] coil_enabled, [4] short_press
    output logic [bcic_pkg::TDATA_W-1:0]        m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [bcic_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bcic_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    // configuration
    logic [7:0]  debounce_period_reg;
    logic [7:0]  long_press_count_reg;
    logic [15:0] coil_delay_reg;
    logic [7:0]  led_period_reg;
    logic [7:0]  slow_blink_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_period_reg  <= bcic_pkg::DEBOUNCE_PERIOD_RST;
            long_press_count_reg <= bcic_pkg::LONG_PRESS_COUNT_RST;
            coil_delay_reg       <= bcic_pkg::COIL_DELAY_RST;
            led_period_reg       <= bcic_pkg::LED_PERIOD_RST;
            slow_blink_count_reg <= bcic_pkg::SLOW_BLINK_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                bcic_pkg::REG_DEBOUNCE_PERIOD:  debounce_period_reg  <= cfg_wr_data[7:0];
                bcic_pkg::REG_LONG_PRESS_COUNT: long_press_count_reg <= cfg_wr_data[7:0];
                bcic_pkg::REG_COIL_DELAY:       coil_delay_reg       <= cfg_wr_data;
                bcic_pkg::REG_LED_PERIOD:       led_period_reg       <= cfg_wr_data[7:0];
                bcic_pkg::REG_SLOW_BLINK_COUNT: slow_blink_count_reg <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic in_valid_reg;
    logic button_reg;
    logic out_valid_reg;
    logic [bcic_pkg::TDATA_W-1:0] out_data_reg;
    logic advance;
    logic step;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // tick state
    logic        delay_running_reg,  delay_running_next;
    logic [15:0] delay_ticks_reg,    delay_ticks_next;
    logic [7:0]  sample_ticks_reg,   sample_ticks_next;
    logic [7:0]  indicator_ticks_reg, indicator_ticks_next;
    logic [7:0]  held_samples_reg,   held_samples_next;
    logic [7:0]  slow_periods_reg,   slow_periods_next;
    logic        disabled_reg,       disabled_next;
    logic        pressed_reg,        pressed_next;
    logic        coil_reg,           coil_next;
    logic        indicator_flag_reg, indicator_flag_next;
    logic        led_reg,            led_next;
    logic        buzzer_reg,         buzzer_next;
    bcic_pkg::result_t result;

    always_comb
    begin
        delay_running_next   = delay_running_reg;
        held_samples_next    = held_samples_reg;
        slow_periods_next    = slow_periods_reg;
        disabled_next        = disabled_reg;
        pressed_next         = pressed_reg;
        coil_next            = coil_reg;
        indicator_flag_next  = indicator_flag_reg;
        led_next             = led_reg;
        buzzer_next          = buzzer_reg;

        // saturating tick counters
        delay_ticks_next = (delay_running_reg && delay_ticks_reg != 16'hFFFF)
                           ? delay_ticks_reg + 16'd1 : delay_ticks_reg;
        sample_ticks_next = (sample_ticks_reg != 8'hFF)
                            ? sample_ticks_reg + 8'd1 : sample_ticks_reg;
        indicator_ticks_next = (indicator_ticks_reg != 8'hFF)
                               ? indicator_ticks_reg + 8'd1 : indicator_ticks_reg;

        // button sample
        if (sample_ticks_next >= debounce_period_reg)
        begin
            sample_ticks_next = '0;
            if (button_reg)
            begin
                pressed_next = 1'b1;
                if (held_samples_reg >= long_press_count_reg)
                begin
                    held_samples_next = '0;
                    disabled_next     = !disabled_reg;
                end
                else
                begin
                    held_samples_next = held_samples_reg + 8'd1;
                end
            end
            else
            begin
                held_samples_next = '0;
                pressed_next      = 1'b0;
            end
        end

        // indicator update
        if (indicator_ticks_next >= led_period_reg)
        begin
            indicator_ticks_next = '0;
            priority if (coil_reg)
            begin
                if (!indicator_flag_reg)
                begin
                    indicator_flag_next = 1'b1;
                    led_next            = 1'b1;
                    buzzer_next         = 1'b0;
                end
            end
            else if (!disabled_next)
            begin
                indicator_flag_next = !indicator_flag_reg;
                led_next            = !indicator_flag_reg;
                buzzer_next         = indicator_flag_reg;
            end
            else if (slow_periods_reg >= slow_blink_count_reg)
            begin
                slow_periods_next = '0;
                if (!indicator_flag_reg)
                begin
                    indicator_flag_next = 1'b1;
                    led_next            = 1'b1;
                    buzzer_next         = 1'b1;
                end
            end
            else
            begin
                slow_periods_next = slow_periods_reg + 8'd1;
                if (indicator_flag_reg)
                begin
                    indicator_flag_next = 1'b0;
                    led_next            = 1'b0;
                    buzzer_next         = 1'b0;
                end
            end
        end

        // coil delay
        priority if (!delay_running_reg && !disabled_next && pressed_next)
        begin
            delay_running_next = 1'b1;
        end
        else if (delay_running_reg && disabled_next)
        begin
            delay_ticks_next   = '0;
            delay_running_next = 1'b0;
        end
        else if (delay_running_reg)
        begin
            if (delay_ticks_next >= coil_delay_reg)
            begin
                delay_ticks_next   = '0;
                delay_running_next = 1'b0;
                coil_next          = 1'b1;
            end
            else
            begin
                coil_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        result.coil_on      = coil_next;
        result.led_lit      = led_next;
        result.buzzer_on    = buzzer_next;
        result.coil_enabled = !disabled_next;
        result.short_press  = pressed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            delay_running_reg   <= 1'b1;
            delay_ticks_reg     <= '0;
            sample_ticks_reg    <= '0;
            indicator_ticks_reg <= '0;
            held_samples_reg    <= '0;
            slow_periods_reg    <= '0;
            disabled_reg        <= 1'b1;
            pressed_reg         <= 1'b0;
            coil_reg            <= 1'b0;
            indicator_flag_reg  <= 1'b0;
            led_reg             <= 1'b1;
            buzzer_reg          <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                delay_running_reg   <= delay_running_next;
                delay_ticks_reg     <= delay_ticks_next;
                sample_ticks_reg    <= sample_ticks_next;
                indicator_ticks_reg <= indicator_ticks_next;
                held_samples_reg    <= held_samples_next;
                slow_periods_reg    <= slow_periods_next;
                disabled_reg        <= disabled_next;
                pressed_reg         <= pressed_next;
                coil_reg            <= coil_next;
                indicator_flag_reg  <= indicator_flag_next;
                led_reg             <= led_next;
                buzzer_reg          <= buzzer_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            button_reg <= s_axis_tdata[0];
        end
        if (step)
        begin
            out_data_reg <= {{(bcic_pkg::TDATA_W - bcic_pkg::OUT_FIELDS){1'b0}}, result};
        end
    end

endmodule

// File: rtl/core/bcic_checker.sv
// ----------------------------------------------------------------------------
// bcic_checker
// Port-level checks on the controller's result stream and flow control.
// ----------------------------------------------------------------------------
module bcic_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bcic_pkg::TDATA_W-1:0]  m_axis_tdata
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed or dropped under stall");

    // padding above the five flags stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[bcic_pkg::TDATA_W-1:bcic_pkg::OUT_FIELDS] == '0)
    else $error("nonzero padding in result word");

    // with the result register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

    // a result only leaves once taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result word vanished without handshake");

    // nothing leaves without an earlier word in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid, 2) || $past(s_axis_tvalid, 1)
            || $past(!s_axis_tready, 1))
    else $error("result word appeared without input");

endmodule

bind button_coil_indicator_controller_top bcic_checker u_bcic_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
